>>> rtl/mbd_pkg.sv
// mbd_pkg: shared types and constants of the MBAP response deframer.
// Used by every module in rtl/; depends on nothing.
package mbd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 260;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // MBAP header length in front of the length field's count
  localparam logic [16:0] MBAP_HDR_BYTES = 17'd6;
  localparam logic [7:0]  EXC_FLAG       = 8'h80;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_ACCEPTED = 3'd1,
    KIND_ID_MISS  = 3'd2,
    KIND_EXCEPT   = 3'd3,
    KIND_SHORT    = 3'd4,
    KIND_BAD_CNT  = 3'd5,
    KIND_BAD_LEN  = 3'd6
  } kind_t;

  // Work for the back end, made from one received byte
  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic       has_status;
    kind_t      kind;
    logic [7:0] code;     // exception code or payload count, by kind
  } mbd_item_t;

endpackage

>>> rtl/mbap_response_deframer.sv
// mbap_response_deframer: Modbus TCP response deframer, top level.
// Depends on mbd_pkg, mbd_front, mbd_queue and mbd_back.
//
// Usage:
//   in_*  : one received byte per item (in_rx_byte), valid/stall handshake.
//   out_* : result items (kind, data value, exception code, payload count, last),
//           valid/stall handshake; out_last marks the final result of a byte.
//   cfg_* : write of the expected transaction id; cfg_ready is always high, write
//           only while no frame is in flight.
// Path: the front writes a byte's work item into the queue at the edge that
// accepts the byte; the back loads the output register from the queue head, and
// a second result of the same byte is loaded from the same entry after the first.
// Throughput: one byte per cycle while the queue is not full. A byte that both
// closes a frame and carries a payload byte makes two results; the queue absorbs
// the extra one, so back-to-back frames of at least two bytes keep full rate.
// Receiver stall: results hold in the output register, the queue fills, and
// in_stall rises when the queue is full. Bytes that make no result (header,
// dropped payload) never enter the queue.
// Reset: synchronous, active low; clears frame state, expected id, queue and
// the output valid. No clearing pass is needed.
module mbap_response_deframer #(
  parameter int MAX_FRAME_BYTES = mbd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = mbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_value,
  output logic [7:0]  out_exception_code,
  output logic [7:0]  out_payload_count,
  output logic        out_last
);

  logic               q_full;
  logic               accept;
  logic               push;
  mbd_pkg::mbd_item_t push_item;
  logic               pop;
  logic               head_valid;
  mbd_pkg::mbd_item_t head_item;

  assign cfg_ready = 1'b1;
  // stall on a full queue, whether or not the byte would make a result
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  mbd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .push      (push),
    .push_item (push_item)
  );

  mbd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  mbd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_item          (head_item),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_data_value     (out_data_value),
    .out_exception_code (out_exception_code),
    .out_payload_count  (out_payload_count),
    .out_last           (out_last)
  );

endmodule

>>> rtl/mbd_front.sv
// mbd_front: frame position tracking, header capture and classification of each byte.
// Depends on mbd_pkg; pushes work items into mbd_queue.
module mbd_front #(
  parameter int MAX_FRAME_BYTES = mbd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output mbd_pkg::mbd_item_t push_item
);

  localparam logic [8:0] POS_ID_HI  = 9'd0;
  localparam logic [8:0] POS_ID_LO  = 9'd1;
  localparam logic [8:0] POS_LEN_HI = 9'd4;
  localparam logic [8:0] POS_LEN_LO = 9'd5;
  localparam logic [8:0] POS_UNIT   = 9'd6;
  localparam logic [8:0] POS_FUNC   = 9'd7;
  localparam logic [8:0] POS_COUNT  = 9'd8;
  localparam logic [8:0] POS_PAYLD  = 9'd9;

  logic [15:0] exp_id_r;
  logic [8:0]  pos_r, pos_nxt;
  logic [8:0]  ft_r, ft_nxt;
  logic [7:0]  id_hi_r, id_hi_nxt;
  logic        id_match_r, id_match_nxt;
  logic        is_exc_r, is_exc_nxt;
  logic [7:0]  exc_code_r, exc_code_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        too_big_r, too_big_nxt;

  logic [15:0] len;
  logic [16:0] len_sum;
  logic        bad_len;
  logic        frame_end;
  mbd_pkg::mbd_item_t item;

  assign len     = {ft_r[7:0], rx_byte};
  assign len_sum = {1'b0, len} + mbd_pkg::MBAP_HDR_BYTES;

  always_comb begin
    pos_nxt      = pos_r;
    ft_nxt       = ft_r;
    id_hi_nxt    = id_hi_r;
    id_match_nxt = id_match_r;
    is_exc_nxt   = is_exc_r;
    exc_code_nxt = exc_code_r;
    count_nxt    = count_r;
    too_big_nxt  = too_big_r;
    bad_len      = 1'b0;
    item         = '0;
    item.kind    = mbd_pkg::KIND_DATA;

    case (pos_r)
      POS_ID_HI: id_hi_nxt = rx_byte;
      POS_ID_LO: id_match_nxt = ({id_hi_r, rx_byte} == exp_id_r);
      POS_LEN_HI: ft_nxt = {1'b0, rx_byte};
      POS_LEN_LO: begin
        if (len == 16'd0 || len_sum > 17'(MAX_FRAME_BYTES)) begin
          ft_nxt = '0;
        end else begin
          ft_nxt = len_sum[8:0];
        end
      end
      POS_UNIT: bad_len = (ft_r == 9'd0);
      POS_FUNC: is_exc_nxt = ((rx_byte & mbd_pkg::EXC_FLAG) != 8'd0);
      POS_COUNT: begin
        exc_code_nxt = rx_byte;
        count_nxt    = rx_byte;
        too_big_nxt  = (10'd9 + 10'(rx_byte)) > {1'b0, ft_r};
      end
      default: begin
        if (pos_r >= POS_PAYLD && id_match_r && !is_exc_r && !too_big_r &&
            ({1'b0, pos_r} < 10'd9 + 10'(count_r))) begin
          item.has_data = 1'b1;
          item.data     = rx_byte;
        end
      end
    endcase

    // status uses header fields as updated by this byte
    frame_end = !bad_len && pos_r >= POS_UNIT &&
                ({1'b0, pos_r} + 10'd1 == {1'b0, ft_nxt});

    if (bad_len) begin
      item.has_status = 1'b1;
      item.kind       = mbd_pkg::KIND_BAD_LEN;
    end else if (frame_end) begin
      item.has_status = 1'b1;
      if (!id_match_nxt) begin
        item.kind = mbd_pkg::KIND_ID_MISS;
      end else if (ft_nxt < 9'd8) begin
        item.kind = mbd_pkg::KIND_SHORT;
      end else if (is_exc_nxt) begin
        item.kind = mbd_pkg::KIND_EXCEPT;
        item.code = exc_code_nxt;
      end else if (ft_nxt < 9'd9) begin
        item.kind = mbd_pkg::KIND_SHORT;
      end else if (too_big_nxt) begin
        item.kind = mbd_pkg::KIND_BAD_CNT;
      end else begin
        item.kind = mbd_pkg::KIND_ACCEPTED;
        item.code = count_nxt;
      end
    end

    if (bad_len || frame_end) begin
      pos_nxt      = '0;
      ft_nxt       = '0;
      id_hi_nxt    = '0;
      id_match_nxt = 1'b0;
      is_exc_nxt   = 1'b0;
      exc_code_nxt = '0;
      count_nxt    = '0;
      too_big_nxt  = 1'b0;
    end else begin
      pos_nxt = pos_r + 9'd1;
    end
  end

  assign push      = accept && (item.has_data || item.has_status);
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r   <= '0;
      pos_r      <= '0;
      ft_r       <= '0;
      id_hi_r    <= '0;
      id_match_r <= 1'b0;
      is_exc_r   <= 1'b0;
      exc_code_r <= '0;
      count_r    <= '0;
      too_big_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        exp_id_r <= cfg_data;
      end
      if (accept) begin
        pos_r      <= pos_nxt;
        ft_r       <= ft_nxt;
        id_hi_r    <= id_hi_nxt;
        id_match_r <= id_match_nxt;
        is_exc_r   <= is_exc_nxt;
        exc_code_r <= exc_code_nxt;
        count_r    <= count_nxt;
        too_big_r  <= too_big_nxt;
      end
    end
  end

endmodule

>>> rtl/mbd_queue.sv
// mbd_queue: short FIFO of work items between the front and back ends.
// Depends on mbd_pkg.
module mbd_queue #(
  parameter int DEPTH = mbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mbd_pkg::mbd_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output mbd_pkg::mbd_item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  mbd_pkg::mbd_item_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slots_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/mbd_back.sv
// mbd_back: turns queued work items into result items in an output register,
// one per cycle while not stalled. Depends on mbd_pkg; reads mbd_queue.
module mbd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  mbd_pkg::mbd_item_t head_item,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_data_value,
  output logic [7:0]         out_exception_code,
  output logic [7:0]         out_payload_count,
  output logic               out_last
);

  logic       valid_r;
  logic       phase_r;      // data half of a two-result item already sent
  logic [2:0] kind_r;
  logic [7:0] data_r, exc_r, cnt_r;
  logic       last_r;
  logic       load;
  logic       send_data;

  assign load      = !valid_r || !out_stall;
  assign send_data = head_item.has_data && !phase_r;
  assign pop       = load && head_valid && (!send_data || !head_item.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= head_valid;
      if (head_valid) begin
        phase_r <= send_data && head_item.has_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (send_data) begin
        kind_r <= mbd_pkg::KIND_DATA;
        data_r <= head_item.data;
        exc_r  <= '0;
        cnt_r  <= '0;
        last_r <= !head_item.has_status;
      end else begin
        kind_r <= head_item.kind;
        data_r <= '0;
        exc_r  <= (head_item.kind == mbd_pkg::KIND_EXCEPT) ? head_item.code : 8'd0;
        cnt_r  <= (head_item.kind == mbd_pkg::KIND_ACCEPTED) ? head_item.code : 8'd0;
        last_r <= 1'b1;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_data_value     = data_r;
  assign out_exception_code = exc_r;
  assign out_payload_count  = cnt_r;
  assign out_last           = last_r;

endmodule

>>> rtl/mbd_checker.sv
// mbd_checker: port-level assertions for mbap_response_deframer, with its bind.
// Depends on mbd_pkg.
module mbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic [7:0] out_data_value,
  input logic [7:0] out_exception_code,
  input logic [7:0] out_payload_count,
  input logic       out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every status closes the results of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != mbd_pkg::KIND_DATA |-> out_last)
    else $error("status result without last");

  a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_kind == mbd_pkg::KIND_DATA || out_data_value == 8'd0) &&
      (out_kind == mbd_pkg::KIND_EXCEPT || out_exception_code == 8'd0) &&
      (out_kind == mbd_pkg::KIND_ACCEPTED || out_payload_count == 8'd0))
    else $error("unused result field not zero");

endmodule

bind mbap_response_deframer mbd_checker u_mbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_data_value     (out_data_value),
  .out_exception_code (out_exception_code),
  .out_payload_count  (out_payload_count),
  .out_last           (out_last)
);

>>> bench/mbap_response_deframer_tb.sv
// mbap_response_deframer_tb: self-checking bench for the MBAP response deframer.
// Depends on mbd_pkg and mbap_response_deframer; drives byte streams, predicts each
// result in step with acceptance and checks the result channel in order.
module mbap_response_deframer_tb;

  localparam int FRAME_MAX   = mbd_pkg::MAX_FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT = 500000;

  // One expected or observed result item
  typedef struct packed {
    mbd_pkg::kind_t kind;
    logic [7:0]     data;
    logic [7:0]     code;
    logic [7:0]     count;
    logic           last;
  } result_t;

  // Directed row: a byte, and where it is obvious, the single status it must give
  typedef struct packed {
    logic [7:0]     b;
    logic           typed;
    mbd_pkg::kind_t kind;
    logic [7:0]     code;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_value;
  logic [7:0]  out_exception_code;
  logic [7:0]  out_payload_count;
  logic        out_last;

  // Shadow of the deframer: configuration and frame state
  logic [15:0] expected_id;
  logic [8:0]  fr_pos;
  logic [8:0]  fr_total;
  logic [7:0]  fr_id_hi;
  bit          fr_id_ok;
  bit          fr_exc;
  logic [7:0]  fr_exc_code;
  logic [7:0]  fr_count;
  bit          fr_count_over;

  result_t     byte_results[$];     // what the byte just accepted produces
  result_t     awaited_results[$];  // in flight, oldest first
  int unsigned bytes_sent;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned gap_pct;             // per-byte chance of a sender gap, in percent
  bit          quiet;               // no idling on either side

  // Directed part. Frames run back to back; the register is still at its reset value 0.
  row_t script [0:31] = '{
    // id ffff, length ffff: bad length wins over the id check on the seventh byte
    '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h11, 1'b1, mbd_pkg::KIND_BAD_LEN, 8'h00},
    // length 1: seven-byte frame ends on the unit id, too short
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h01, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h22, 1'b1, mbd_pkg::KIND_SHORT, 8'h00},
    // length 2: eight-byte exception frame with no code byte, code reads as 0
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h02, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h33, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h81, 1'b1, mbd_pkg::KIND_EXCEPT, 8'h00},
    // length 4: one payload byte ff, data and accept come from the same byte
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h00, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h04, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'h03, 1'b0, mbd_pkg::KIND_DATA, 8'h00},
    '{8'h01, 1'b0, mbd_pkg::KIND_DATA, 8'h00}, '{8'hFF, 1'b0, mbd_pkg::KIND_DATA, 8'h00}
  };

  mbap_response_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_value     (out_data_value),
    .out_exception_code (out_exception_code),
    .out_payload_count  (out_payload_count),
    .out_last           (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic result_t make_result(mbd_pkg::kind_t k, logic [7:0] d, logic [7:0] e,
                                          logic [7:0] n);
    result_t r;
    r = '{kind: k, data: d, code: e, count: n, last: 1'b0};
    return r;
  endfunction

  function automatic void clear_frame();
    fr_pos        = '0;
    fr_total      = '0;
    fr_id_hi      = '0;
    fr_id_ok      = 1'b0;
    fr_exc        = 1'b0;
    fr_exc_code   = '0;
    fr_count      = '0;
    fr_count_over = 1'b0;
  endfunction

  // Advance the shadow framer by one byte; its results land in byte_results.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [16:0] len;
    bit          restarted;
    restarted = 1'b0;
    byte_results.delete();
    case (fr_pos)
      0: fr_id_hi = b;
      1: fr_id_ok = ({fr_id_hi, b} == expected_id);
      4: fr_total = {1'b0, b};   // length high byte parked here until byte 5
      5: begin
        len = {1'b0, fr_total[7:0], b};
        if (len == 0 || len + 6 > FRAME_MAX) fr_total = '0;
        else fr_total = 9'(len + 6);
      end
      6: if (fr_total == 0) begin
        // bad length: single status, framer restarts on the next byte
        byte_results.push_back(make_result(mbd_pkg::KIND_BAD_LEN, 8'h00, 8'h00, 8'h00));
        clear_frame();
        restarted = 1'b1;
      end
      7: fr_exc = b[7];
      8: begin
        fr_exc_code   = b;
        fr_count      = b;
        fr_count_over = (9 + b > fr_total);
      end
      default: begin
        // payload goes out only within the declared count of a clean frame
        if (fr_pos >= 9 && fr_id_ok && !fr_exc && !fr_count_over && fr_pos < 9 + fr_count)
          byte_results.push_back(make_result(mbd_pkg::KIND_DATA, b, 8'h00, 8'h00));
      end
    endcase
    if (!restarted) begin
      if (fr_pos >= 6 && fr_pos + 1 == fr_total) begin
        // frame end, status in priority order
        if (!fr_id_ok)
          byte_results.push_back(make_result(mbd_pkg::KIND_ID_MISS, 8'h00, 8'h00, 8'h00));
        else if (fr_total < 8)
          byte_results.push_back(make_result(mbd_pkg::KIND_SHORT, 8'h00, 8'h00, 8'h00));
        else if (fr_exc)
          byte_results.push_back(make_result(mbd_pkg::KIND_EXCEPT, 8'h00, fr_exc_code,
                                             8'h00));
        else if (fr_total < 9)
          byte_results.push_back(make_result(mbd_pkg::KIND_SHORT, 8'h00, 8'h00, 8'h00));
        else if (fr_count_over)
          byte_results.push_back(make_result(mbd_pkg::KIND_BAD_CNT, 8'h00, 8'h00, 8'h00));
        else
          byte_results.push_back(make_result(mbd_pkg::KIND_ACCEPTED, 8'h00, 8'h00,
                                             fr_count));
        clear_frame();
      end else begin
        fr_pos = fr_pos + 9'd1;
      end
    end
    if (byte_results.size() != 0)
      byte_results[byte_results.size() - 1].last = 1'b1;
  endfunction

  // Offer one byte, maybe after a gap; on acceptance queue what it must produce.
  // A typed row replaces the prediction with the status written in the table.
  task automatic offer_byte(input logic [7:0] b, input logic typed,
                            input mbd_pkg::kind_t want_kind, input logic [7:0] want_code);
    result_t r;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    deframe_byte(b);
    if (typed) begin
      r = make_result(want_kind, 8'h00, want_code, 8'h00);
      r.last = 1'b1;
      awaited_results.push_back(r);
    end else begin
      foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
    end
    @(negedge clk);
  endtask

  // Sender holds off until every queued result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  // Register write while idle, once every queued result has come back.
  task automatic write_expected_id(input logic [15:0] v);
    wait_results_drained();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    expected_id = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random frame: mostly well formed responses, some bad lengths, some noise.
  task automatic send_random_frame();
    logic [7:0]  fb[$];
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  fc;
    logic [7:0]  cnt;
    int          flavor;
    int          total;
    int          fit;
    flavor = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: gap_pct = 0;
      1: gap_pct = 4;
      2: gap_pct = 15;
      default: gap_pct = 40;
    endcase
    if (flavor < 15) begin
      // noise, then random bytes until the framer is back at a frame start
      repeat ($urandom_range(1, 12))
        offer_byte(8'($urandom_range(0, 255)), 1'b0, mbd_pkg::KIND_DATA, 8'h00);
      while (fr_pos != 0)
        offer_byte(8'($urandom_range(0, 255)), 1'b0, mbd_pkg::KIND_DATA, 8'h00);
    end else begin
      id = ($urandom_range(0, 9) != 0) ? expected_id : 16'($urandom_range(0, 65535));
      if (flavor < 30) begin
        // zero length, or just past the longest legal frame and beyond
        case ($urandom_range(0, 3))
          0: len = 16'd0;
          1: len = 16'(FRAME_MAX - 5);
          default: len = 16'($urandom_range(FRAME_MAX - 5, 65535));
        endcase
        total = 7;
      end else begin
        case ($urandom_range(0, 19))
          0: len = 16'd1;
          1: len = 16'd2;
          2: len = 16'(FRAME_MAX - 6);
          3, 4: len = 16'($urandom_range(3, FRAME_MAX - 6));
          default: len = 16'($urandom_range(3, 24));
        endcase
        total = 6 + len;
      end
      fc = 8'($urandom_range(0, 255));
      fc[7] = ($urandom_range(0, 3) == 0);
      fit = int'(len) - 3;   // byte count that exactly fills the frame
      if (fit < 0 || fit > 254) begin
        cnt = 8'($urandom_range(0, 255));
      end else begin
        case ($urandom_range(0, 9))
          7: cnt = 8'($urandom_range(0, fit));
          8, 9: cnt = 8'($urandom_range(fit + 1, 255));
          default: cnt = 8'(fit);
        endcase
      end
      fb.push_back(id[15:8]);
      fb.push_back(id[7:0]);
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(len[15:8]);
      fb.push_back(len[7:0]);
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(fc);
      fb.push_back(cnt);
      while (fb.size() < total) fb.push_back(8'($urandom_range(0, 255)));
      while (fb.size() > total) void'(fb.pop_back());
      foreach (fb[i]) offer_byte(fb[i], 1'b0, mbd_pkg::KIND_DATA, 8'h00);
    end
  endtask

  // Receiver: occasional stall bursts, with calm stretches between.
  initial begin : result_stall
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 80)) @(negedge clk);
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t seen;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{kind: mbd_pkg::kind_t'(out_kind), data: out_data_value,
               code: out_exception_code, count: out_payload_count, last: out_last};
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result k%0d d%h e%h n%0d l%b", $time,
                 seen.kind, seen.data, seen.code, seen.count, seen.last);
      end else begin
        want = awaited_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          $display("%0t: expected k%0d d%h e%h n%0d l%b, got k%0d d%h e%h n%0d l%b", $time,
                   want.kind, want.data, want.code, want.count, want.last,
                   seen.kind, seen.data, seen.code, seen.count, seen.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mbap_response_deframer verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] id_plan [0:3];
    int          phase;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = 16'h0000;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    bytes_sent  = 0;
    mismatches  = 0;
    cycle_count = 0;
    gap_pct     = 0;
    quiet       = 1'b0;
    expected_id = 16'h0000;
    clear_frame();
    // extremes first, then two random ids
    id_plan[0] = 16'hFFFF;
    id_plan[1] = 16'h0000;
    id_plan[2] = 16'($urandom_range(0, 65535));
    id_plan[3] = 16'($urandom_range(0, 65535));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    gap_pct = 10;
    foreach (script[i])
      offer_byte(script[i].b, script[i].typed, script[i].kind, script[i].code);

    for (phase = 0; phase < 4; phase++) begin
      write_expected_id(id_plan[phase]);
      quiet = (phase == 3);   // full rate both sides in the final stretch
      while (bytes_sent < 32 + 320 * (phase + 1)) begin
        send_random_frame();
        if ($urandom_range(0, 39) == 0) wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("mbap_response_deframer verification clean");
    end else begin
      $display("mbap_response_deframer verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mbd_pkg.sv
rtl/mbd_front.sv
rtl/mbd_queue.sv
rtl/mbd_back.sv
rtl/mbap_response_deframer.sv
rtl/mbd_checker.sv
bench/mbap_response_deframer_tb.sv
